// ===== src/chmap_pkg.sv =====
// ----------------------------------------------------------------------------
// chmap_pkg
// Types and constants shared by the chained hash map engine: request and
// response beats, operation and status codes, table geometry.
// ----------------------------------------------------------------------------
package chmap_pkg;

  // Table geometry. The bucket count must be a power of two so that the
  // bucket index is simply the low bits of the key.
  localparam int NUM_BUCKETS = 16;
  localparam int CHAIN_DEPTH = 4;

  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int BUCKET_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SLOT_W   = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;

  // Operation codes; the two unused codes fall to the default arm.
  typedef enum logic [2:0] {
    REQ_INSERT           = 3'd0,
    REQ_INSERT_OR_ASSIGN = 3'd1,
    REQ_CONTAINS         = 3'd2,
    REQ_SEARCH           = 3'd3,
    REQ_ERASE            = 3'd4,
    REQ_COUNT            = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_LOOK = 1'b1
  } state_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic signed [KEY_W-1:0]   key;
    logic        [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [VALUE_W-1:0]   value_out;
    logic                 match_count;
  } rsp_t;

  // One slot of a bucket row, and a whole row as held in the memory.
  typedef struct packed {
    logic signed [KEY_W-1:0]   key;
    logic        [VALUE_W-1:0] value;
  } slot_t;

  typedef slot_t [CHAIN_DEPTH-1:0] row_t;

endpackage

// ===== src/chained_hash_map_engine_core.sv =====
// ----------------------------------------------------------------------------
// chained_hash_map_engine_core
// Key-value table with separate chaining. Each bucket is one row of a
// synchronous memory holding all of its slots; the row is read, all slots
// are compared at once, and the modified row is written back.
//
//   channel | direction | handshake              | beat
//   --------+-----------+------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o   | chmap_pkg::req_t
//   out     | output    | out_valid_o / out_stall_i | chmap_pkg::rsp_t
//
// Each request first reads its bucket row from the memory; then, in S_LOOK,
// the row is compared, written back and the result register is loaded.
// Reset clears all slot valid bits at once, so the table is empty at once.
// While the result register still holds an untaken beat, the compare step
// waits in S_LOOK and the input is stalled.
// ----------------------------------------------------------------------------
module chained_hash_map_engine_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  chmap_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output chmap_pkg::rsp_t  out_rsp_o
);

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  chmap_pkg::state_e state_q, state_d;

  chmap_pkg::req_t  req_q;
  chmap_pkg::row_t  mem_rows [chmap_pkg::NUM_BUCKETS];
  chmap_pkg::row_t  rd_row_q;
  chmap_pkg::row_t  wr_row;

  logic [chmap_pkg::NUM_BUCKETS-1:0][chmap_pkg::CHAIN_DEPTH-1:0] valid_q;
  logic [chmap_pkg::CHAIN_DEPTH-1:0] row_valid;
  logic [chmap_pkg::CHAIN_DEPTH-1:0] row_valid_d;
  logic [chmap_pkg::CHAIN_DEPTH-1:0] hit_vec;

  logic [chmap_pkg::BUCKET_W-1:0] rd_bucket;
  logic [chmap_pkg::BUCKET_W-1:0] wr_bucket;

  logic [chmap_pkg::SLOT_W-1:0] hit_idx;
  logic [chmap_pkg::SLOT_W-1:0] free_idx;
  logic                         hit_any;
  logic                         free_any;

  logic            in_accept;
  logic            rd_en;
  logic            finish;
  logic            out_free;
  chmap_pkg::rsp_t rsp;

  logic            out_valid_q;
  chmap_pkg::rsp_t out_q;

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Bucket index: low bits of the key pattern.
  assign rd_bucket = chmap_pkg::BUCKET_W'($unsigned(in_req_i.key) % chmap_pkg::NUM_BUCKETS);
  assign wr_bucket = chmap_pkg::BUCKET_W'($unsigned(req_q.key) % chmap_pkg::NUM_BUCKETS);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chmap_pkg::S_IDLE: begin
        if (in_valid_i) state_d = chmap_pkg::S_LOOK;
      end
      chmap_pkg::S_LOOK: begin
        if (out_free) state_d = chmap_pkg::S_IDLE;
      end
      default: state_d = chmap_pkg::S_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    finish     = 1'b0;
    unique case (state_q)
      chmap_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        rd_en      = in_valid_i;
      end
      chmap_pkg::S_LOOK: begin
        finish = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chmap_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the accepted request for the compare cycle.
  always_ff @(posedge clk_i) begin
    if (in_accept) req_q <= in_req_i;
  end

  // --------------------------------------------------------------------------
  // Bucket memory: one row per bucket, registered read
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (finish) mem_rows[wr_bucket] <= wr_row;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_row_q <= mem_rows[rd_bucket];
  end

  // Slot valid bits, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (finish) begin
      valid_q[wr_bucket] <= row_valid_d;
    end
  end

  assign row_valid = valid_q[wr_bucket];

  // --------------------------------------------------------------------------
  // Compare all slots of the row; pick first hit and first free slot
  // --------------------------------------------------------------------------
  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < chmap_pkg::CHAIN_DEPTH; i++) begin
      hit_vec[i] = row_valid[i] && (rd_row_q[i].key == req_q.key);
      if (hit_vec[i] && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = chmap_pkg::SLOT_W'(i);
      end
      if (!row_valid[i] && !free_any) begin
        free_any = 1'b1;
        free_idx = chmap_pkg::SLOT_W'(i);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Modify the row and build the response
  // --------------------------------------------------------------------------
  always_comb begin
    wr_row          = rd_row_q;
    row_valid_d     = row_valid;
    rsp.status      = chmap_pkg::ST_OK;
    rsp.found       = hit_any;
    rsp.value_out   = '0;
    rsp.match_count = 1'b0;
    case (req_q.req_type) inside
      chmap_pkg::REQ_INSERT, chmap_pkg::REQ_INSERT_OR_ASSIGN: begin
        if (hit_any) begin
          if (req_q.req_type == chmap_pkg::REQ_INSERT) begin
            rsp.status = chmap_pkg::ST_DUPLICATE;
          end else begin
            wr_row[hit_idx].value = req_q.value;
          end
        end else if (!free_any) begin
          rsp.status = chmap_pkg::ST_FULL;
        end else begin
          row_valid_d[free_idx]  = 1'b1;
          wr_row[free_idx].key   = req_q.key;
          wr_row[free_idx].value = req_q.value;
        end
      end
      chmap_pkg::REQ_CONTAINS: begin
        if (!hit_any) rsp.status = chmap_pkg::ST_NOT_FOUND;
      end
      chmap_pkg::REQ_SEARCH: begin
        if (hit_any) begin
          rsp.value_out = rd_row_q[hit_idx].value;
        end else begin
          rsp.status = chmap_pkg::ST_NOT_FOUND;
        end
      end
      chmap_pkg::REQ_ERASE: begin
        if (hit_any) begin
          row_valid_d[hit_idx] = 1'b0;
        end else begin
          rsp.status = chmap_pkg::ST_NOT_FOUND;
        end
      end
      chmap_pkg::REQ_COUNT: begin
        rsp.match_count = hit_any;
      end
      default: begin
        // Unknown operation: table untouched, all-zero response.
        rsp.found = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) out_q <= rsp;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A key is held at most once in its bucket.
  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == chmap_pkg::S_LOOK) |-> $onehot0(hit_vec))
    else $error("key held in more than one slot");

  // One request changes at most one valid bit.
  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> ($countones(row_valid ^ row_valid_d) <= 1))
    else $error("more than one slot changed by one request");

  // An accepted beat is always followed by the compare cycle.
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == chmap_pkg::S_LOOK))
    else $error("accepted beat not followed by compare cycle");

  // A full bucket is only reported when every slot is occupied.
  a_full_real: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish && (rsp.status == chmap_pkg::ST_FULL)) |-> (&row_valid))
    else $error("bucket full reported with a free slot");

  // The result register is never overwritten while its beat is waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !finish)
    else $error("pending result overwritten");

endmodule
